@@ src/rpp_pkg.sv @@
// Shared widths, register codes, depth/pressure tables and types for the pressure profile.
package rpp_pkg;

  localparam int TAB_CAP    = 64;
  localparam int IDX_W      = $clog2(TAB_CAP);
  localparam int ELEV_W     = 32;
  localparam int PRES_W     = 41;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int RHO_W      = 32;
  localparam int GRAV_W     = 24;
  localparam int DEPTH_M_W  = 22;
  localparam int STD_W      = 14;
  localparam int UNITS_W    = 18;   // 1e6 Pa units
  localparam int STEP_W     = 13;   // largest pressure step between points, 1e6 Pa units
  localparam int SPAN_W     = 17;   // largest depth step between points, meters
  localparam int FRAC_W     = SPAN_W + 8;
  localparam int SCALE_W    = 14;
  localparam int KK_W       = STEP_W + SCALE_W;
  localparam int NUM_W      = KK_W + FRAC_W + 1;
  localparam int DEN_W      = SPAN_W + 2;
  localparam int QUO_W      = 33;   // interpolated step stays below 2^33 Pa

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYD_DIFFUSION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_DENSITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_POROSITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY       = 3'd4;

  localparam logic [1:0] MODE_LITHO  = 2'd0;
  localparam logic [1:0] MODE_STD    = 2'd1;
  localparam logic [1:0] MODE_CRUST  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [15:0]        WATER_DENSITY = 16'd1000;
  localparam logic [SCALE_W-1:0] PA_SCALE      = 14'd15625;   // 1e6 / 64
  localparam logic [19:0]        MEGA          = 20'd1000000;
  localparam logic [3:0]         STD_TO_UNITS  = 4'd10;

  localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
  localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

  localparam logic [DEPTH_M_W-1:0] TAB_DEPTH_M [TAB_CAP] = '{
    22'd0, 22'd3000, 22'd15000, 22'd24400, 22'd40000, 22'd60000, 22'd80000, 22'd115000,
    22'd150000, 22'd185000, 22'd220000, 22'd265000, 22'd310000, 22'd355000, 22'd400000,
    22'd450000, 22'd500000, 22'd550000, 22'd600000, 22'd635000, 22'd670000, 22'd721000,
    22'd771000, 22'd871000, 22'd971000, 22'd1071000, 22'd1171000, 22'd1271000, 22'd1371000,
    22'd1471000, 22'd1571000, 22'd1671000, 22'd1771000, 22'd1871000, 22'd1971000,
    22'd2071000, 22'd2171000, 22'd2271000, 22'd2371000, 22'd2471000, 22'd2571000,
    22'd2671000, 22'd2741000, 22'd2771000, 22'd2871000, 22'd2891000,
    22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0,
    22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  // 1e7 Pa units
  localparam logic [STD_W-1:0] TAB_STD [TAB_CAP] = '{
    14'd0, 14'd3, 14'd33, 14'd60, 14'd112, 14'd178, 14'd245, 14'd361, 14'd478, 14'd594,
    14'd711, 14'd864, 14'd1020, 14'd1177, 14'd1335, 14'd1522, 14'd1713, 14'd1907, 14'd2104,
    14'd2243, 14'd2383, 14'd2607, 14'd2829, 14'd3276, 14'd3728, 14'd4186, 14'd4648, 14'd5116,
    14'd5589, 14'd6068, 14'd6552, 14'd7041, 14'd7535, 14'd8036, 14'd8543, 14'd9056, 14'd9576,
    14'd10103, 14'd10638, 14'd11182, 14'd11734, 14'd12297, 14'd12697, 14'd12870, 14'd13456,
    14'd13575,
    14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
    14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
  };

  // 1e6 Pa units
  localparam logic [UNITS_W-1:0] TAB_CRUST [TAB_CAP] = '{
    18'd0, 18'd82, 18'd410, 18'd670, 18'd1120, 18'd1780, 18'd2450, 18'd3610, 18'd4780,
    18'd5940, 18'd7110, 18'd8640, 18'd10200, 18'd11770, 18'd13350, 18'd15220, 18'd17130,
    18'd19070, 18'd21040, 18'd22430, 18'd23830, 18'd26070, 18'd28290, 18'd32760, 18'd37280,
    18'd41860, 18'd46480, 18'd51160, 18'd55890, 18'd60680, 18'd65520, 18'd70410, 18'd75350,
    18'd80360, 18'd85430, 18'd90560, 18'd95760, 18'd101030, 18'd106380, 18'd111820,
    18'd117340, 18'd122970, 18'd126970, 18'd128700, 18'd134560, 18'd135750,
    18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0,
    18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0
  };

  typedef struct packed {
    logic signed [PRES_W-1:0] base;
    logic                     sat;
  } rpp_side_t;

  function automatic logic [UNITS_W-1:0] tab_units(input logic crust,
                                                   input logic [IDX_W-1:0] idx);
    logic [UNITS_W-1:0] u;
    if (crust) begin
      u = TAB_CRUST[idx];
    end else begin
      u = UNITS_W'(TAB_STD[idx]) * UNITS_W'(STD_TO_UNITS);
    end
    return u;
  endfunction

endpackage

@@ src/rpp_in_if.sv @@
// Input channel: one elevation per beat.
interface rpp_in_if;
  import rpp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] elevation;
  modport source (output valid, output elevation, input ready);
  modport sink (input valid, input elevation, output ready);
endinterface

@@ src/rpp_out_if.sv @@
// Output channel: one pressure and saturation flag per beat.
interface rpp_out_if;
  import rpp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PRES_W-1:0] pressure;
  logic                     saturated;
  modport source (output valid, output pressure, output saturated, input ready);
  modport sink (input valid, input pressure, input saturated, output ready);
endinterface

@@ src/rpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband carried alongside.
module rpp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [rpp_pkg::NUM_W-1:0]     numer,
  input  logic [rpp_pkg::DEN_W-1:0]     den,
  input  rpp_pkg::rpp_side_t            side_in,
  output logic                          out_v,
  output logic [rpp_pkg::QUO_W-1:0]     quo,
  output rpp_pkg::rpp_side_t            side_out
);
  import rpp_pkg::*;

  logic [QUO_W-1:0] vld;
  logic [DEN_W-1:0] rem [QUO_W];
  logic [QUO_W-1:0] shq [QUO_W];   // numerator bits leave the top, quotient bits enter below
  logic [DEN_W-1:0] dvs [QUO_W];
  rpp_side_t        sb  [QUO_W];
  logic [DEN_W-1:0] rem_next [QUO_W];
  logic [QUO_W-1:0] shq_next [QUO_W];

  // numerator top part is below the divisor, so the quotient fits QUO_W bits
  always_comb begin
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QUO_W-1:0] s_in;
    logic [DEN_W:0]   trial;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        r_in = DEN_W'(numer[NUM_W-1:QUO_W]);
        s_in = numer[QUO_W-1:0];
        d_in = den;
      end else begin
        r_in = rem[k-1];
        s_in = shq[k-1];
        d_in = dvs[k-1];
      end
      trial = {r_in, s_in[QUO_W-1]};
      if (trial >= {1'b0, d_in}) begin
        rem_next[k] = DEN_W'(trial - {1'b0, d_in});
        shq_next[k] = {s_in[QUO_W-2:0], 1'b1};
      end else begin
        rem_next[k] = DEN_W'(trial);
        shq_next[k] = {s_in[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem[k] <= rem_next[k];
        shq[k] <= shq_next[k];
      end
      dvs[0] <= den;
      sb[0]  <= side_in;
      for (int k = 1; k < QUO_W; k++) begin
        dvs[k] <= dvs[k-1];
        sb[k]  <= sb[k-1];
      end
    end
  end

  assign out_v    = vld[QUO_W-1];
  assign quo      = shq[QUO_W-1];
  assign side_out = sb[QUO_W-1];

endmodule

@@ src/reference_pressure_profile.sv @@
// Top level: elevation to reference pressure, lithostatic or table interpolation.
// Takes one elevation beat per clock and returns one pressure beat per elevation, in order.
// The pipeline has eight front stages (input register, magnitude, density and breakpoint
// compares, segment select, partial products and table reads, rounding and segment setup,
// saturation and scaling, interpolation product, divider operands), then a 33-stage
// restoring divider that resolves one quotient bit per stage, then the output register.
// Sustained rate is one beat per cycle; while a finished result is held by the sink the
// whole pipeline holds and sample.ready is low.
// Mode 0 rounds density * gravity * depth half away from zero and clamps to 41 bits,
// flagging the clamp; modes 1 and 2 interpolate between breakpoints, give 0 at or above
// the surface and the last table pressure past the last breakpoint. Configuration writes
// also reach beats already in flight and are expected only while the pipeline is empty.
module reference_pressure_profile #(
  parameter int TABLE_POINTS = 46
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  rpp_in_if.sink                           sample,
  rpp_out_if.source                        result
);
  import rpp_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_POINTS - 1);
  localparam int A_W        = RHO_W + GRAV_W;
  localparam int HALF_W     = A_W / 2;
  localparam int PP_W       = HALF_W + ELEV_W;
  localparam int SUM_W      = A_W + ELEV_W;
  localparam int RND_SHIFT  = 40;
  localparam int RES_W      = SUM_W - RND_SHIFT;
  localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SHIFT - 1);
  localparam logic [RES_W-1:0] NEG_LIMIT = RES_W'(1) << (PRES_W - 1);

  // configuration
  logic [1:0]        pressure_mode;
  logic              hydraulic_diffusion;
  logic [15:0]       ref_density;
  logic [15:0]       ref_porosity;
  logic [GRAV_W-1:0] gravity;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_mode       <= MODE_LITHO;
      hydraulic_diffusion <= 1'b0;
      ref_density         <= 16'd3000;
      ref_porosity        <= 16'd0;
      gravity             <= 24'd655360;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_PRESSURE_MODE: pressure_mode       <= cfg_data[1:0];
        CFG_HYD_DIFFUSION: hydraulic_diffusion <= cfg_data[0];
        CFG_REF_DENSITY:   ref_density         <= cfg_data[15:0];
        CFG_REF_POROSITY:  ref_porosity        <= cfg_data[15:0];
        CFG_GRAVITY:       gravity             <= cfg_data[GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  logic       en;
  logic [8:1] vs;
  logic       crust;
  logic       table_mode;

  assign en         = !result.valid || result.ready;
  assign sample.ready = en;
  assign crust      = (pressure_mode == MODE_CRUST);
  assign table_mode = pressure_mode inside {MODE_STD, MODE_CRUST};

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[7:1], sample.valid};
    end
  end

  // stage 1
  logic signed [ELEV_W-1:0] e1;

  // stage 2: magnitude, density, breakpoint compares
  logic [ELEV_W-1:0]    mag_c;
  logic [16:0]          dry_frac;
  logic [RHO_W:0]       mix_c;
  logic [RHO_W-1:0]     rho_c;
  logic [TAB_CAP-1:1]   le_c;
  logic                 neg2;
  logic                 surf2;
  logic [ELEV_W-1:0]    mag2;
  logic [RHO_W-1:0]     rho2;
  logic [TAB_CAP-1:1]   le2;

  assign mag_c    = e1[ELEV_W-1] ? unsigned'(-e1) : unsigned'(e1);
  assign dry_frac = {1'b0, ~ref_porosity} + 17'd1;
  assign mix_c    = (RHO_W+1)'(ref_density) * (RHO_W+1)'(dry_frac)
                  + (RHO_W+1)'(WATER_DENSITY) * (RHO_W+1)'(ref_porosity);
  assign rho_c    = hydraulic_diffusion ? RHO_W'(mix_c) : {ref_density, 16'b0};

  always_comb begin
    for (int i = 1; i < TAB_CAP; i++) begin
      le_c[i] = (i < TABLE_POINTS) && (mag_c <= ELEV_W'({TAB_DEPTH_M[i], 8'b0}));
    end
  end

  // stage 3: segment select, density times gravity
  logic [IDX_W-1:0] n_c;
  logic             neg3;
  logic             surf3;
  logic             past3;
  logic [ELEV_W-1:0] mag3;
  logic [A_W-1:0]   a3;
  logic [IDX_W-1:0] n3;

  always_comb begin
    n_c = '0;
    for (int i = TAB_CAP - 1; i >= 1; i--) begin
      if (le2[i]) begin
        n_c = IDX_W'(i);
      end
    end
  end

  // stage 4: partial products, table reads
  logic [IDX_W-1:0]     i0_c;
  logic                 neg4;
  logic                 surf4;
  logic                 past4;
  logic [ELEV_W-1:0]    mag4;
  logic [PP_W-1:0]      lo4;
  logic [PP_W-1:0]      hi4;
  logic [UNITS_W-1:0]   u0_4;
  logic [UNITS_W-1:0]   u1_4;
  logic [DEPTH_M_W-1:0] dm0_4;
  logic [DEPTH_M_W-1:0] dm1_4;

  assign i0_c = past3 ? LAST : n3 - 1'b1;

  // stage 5: rounding, segment setup
  logic [SUM_W-1:0]  sum_c;
  logic              neg5;
  logic              surf5;
  logic              past5;
  logic [RES_W-1:0]  res5;
  logic [STEP_W-1:0] k5;
  logic [SPAN_W-1:0] dd5;
  logic [FRAC_W-1:0] frac5;
  logic [PRES_W-1:0] p0_5;

  assign sum_c = SUM_W'(lo4) + {hi4, {HALF_W{1'b0}}} + RND_HALF;

  // stage 6: saturation, base select, step scaling
  logic signed [PRES_W-1:0] lit_c;
  logic                     lit_sat_c;
  logic signed [PRES_W-1:0] base_c;
  logic                     sat_c;
  rpp_side_t                side6;
  logic                     interp6;
  logic [KK_W-1:0]          kk6;
  logic [FRAC_W-1:0]        frac6;
  logic [SPAN_W-1:0]        dd6;

  always_comb begin
    if (neg5) begin
      lit_sat_c = res5 > NEG_LIMIT;
      lit_c     = lit_sat_c ? PRES_MIN : signed'(PRES_W'(~res5[PRES_W-1:0] + 1'b1));
    end else begin
      lit_sat_c = res5[RES_W-1:PRES_W-1] != '0;
      lit_c     = lit_sat_c ? PRES_MAX : signed'(res5[PRES_W-1:0]);
    end
  end

  always_comb begin
    case (pressure_mode)
      MODE_LITHO: begin
        base_c = lit_c;
        sat_c  = lit_sat_c;
      end
      MODE_STD, MODE_CRUST: begin
        base_c = surf5 ? '0 : signed'(p0_5);
        sat_c  = 1'b0;
      end
      default: begin
        base_c = '0;
        sat_c  = 1'b0;
      end
    endcase
  end

  // stage 7: interpolation product
  logic [NUM_W-1:0]  n7;
  logic [SPAN_W-1:0] dd7;
  logic              interp7;
  rpp_side_t         side7;

  // stage 8: divider operands
  logic [NUM_W-1:0] numer8;
  logic [DEN_W-1:0] den8;
  rpp_side_t        side8;

  always_ff @(posedge clk) begin
    if (en) begin
      e1      <= sample.elevation;

      neg2    <= !e1[ELEV_W-1] && (e1 != '0);
      surf2   <= !e1[ELEV_W-1];
      mag2    <= mag_c;
      rho2    <= rho_c;
      le2     <= le_c;

      neg3    <= neg2;
      surf3   <= surf2;
      past3   <= (le2 == '0);
      mag3    <= mag2;
      a3      <= A_W'(rho2) * A_W'(gravity);
      n3      <= n_c;

      neg4    <= neg3;
      surf4   <= surf3;
      past4   <= past3;
      mag4    <= mag3;
      lo4     <= PP_W'(a3[HALF_W-1:0]) * PP_W'(mag3);
      hi4     <= PP_W'(a3[A_W-1:HALF_W]) * PP_W'(mag3);
      u0_4    <= tab_units(crust, i0_c);
      u1_4    <= tab_units(crust, n3);
      dm0_4   <= TAB_DEPTH_M[i0_c];
      dm1_4   <= TAB_DEPTH_M[n3];

      neg5    <= neg4;
      surf5   <= surf4;
      past5   <= past4;
      res5    <= sum_c[SUM_W-1:RND_SHIFT];
      k5      <= STEP_W'(u1_4 - u0_4);
      dd5     <= SPAN_W'(dm1_4 - dm0_4);
      frac5   <= FRAC_W'(mag4 - ELEV_W'({dm0_4, 8'b0}));
      p0_5    <= PRES_W'(u0_4) * PRES_W'(MEGA);

      side6   <= '{base: base_c, sat: sat_c};
      interp6 <= table_mode && !surf5 && !past5;
      kk6     <= KK_W'(k5) * KK_W'(PA_SCALE);
      frac6   <= frac5;
      dd6     <= dd5;

      n7      <= NUM_W'(kk6) * NUM_W'(frac6);
      dd7     <= dd6;
      interp7 <= interp6;
      side7   <= side6;

      // half of the divisor added for round-half-up
      numer8  <= interp7 ? n7 + NUM_W'({dd7, 1'b0}) : '0;
      den8    <= interp7 ? {dd7, 2'b00} : '1;
      side8   <= side7;
    end
  end

  logic             dv;
  logic [QUO_W-1:0] quo;
  rpp_side_t        dside;

  rpp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (vs[8]),
    .numer    (numer8),
    .den      (den8),
    .side_in  (side8),
    .out_v    (dv),
    .quo      (quo),
    .side_out (dside)
  );

  logic                     out_v;
  logic signed [PRES_W-1:0] out_p;
  logic                     out_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p <= dside.base + signed'(PRES_W'(quo));
      out_s <= dside.sat;
    end
  end

  assign result.valid     = out_v;
  assign result.pressure  = out_p;
  assign result.saturated = out_s;

  a_table_unsat: assert property (@(posedge clk) disable iff (rst)
    result.valid && (pressure_mode != MODE_LITHO)
      |-> !result.saturated && !result.pressure[PRES_W-1])
    else $error("table mode result saturated or negative");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated
      |-> (result.pressure == PRES_MAX) || (result.pressure == PRES_MIN))
    else $error("saturated result not at a bound");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (pressure_mode == MODE_UNUSED) |-> (result.pressure == '0))
    else $error("unused mode gave nonzero pressure");

endmodule

@@ test/tb_top.sv @@
// Testbench for the reference pressure profile: queued elevations, in-bench predictor, checker.
`timescale 1ns / 1ps

module tb_top;
  import rpp_pkg::*;

  localparam int POINTS      = 46;
  localparam int LATENCY     = 41;
  localparam int CYCLE_LIMIT = 400000;

  localparam longint BREAK_DEPTH_M [POINTS] = '{
    0, 3000, 15000, 24400, 40000, 60000, 80000, 115000, 150000, 185000,
    220000, 265000, 310000, 355000, 400000, 450000, 500000, 550000, 600000, 635000,
    670000, 721000, 771000, 871000, 971000, 1071000, 1171000, 1271000, 1371000, 1471000,
    1571000, 1671000, 1771000, 1871000, 1971000, 2071000, 2171000, 2271000, 2371000,
    2471000, 2571000, 2671000, 2741000, 2771000, 2871000, 2891000 };

  // 1e7 Pa units
  localparam longint STD_10MPA [POINTS] = '{
    0, 3, 33, 60, 112, 178, 245, 361, 478, 594,
    711, 864, 1020, 1177, 1335, 1522, 1713, 1907, 2104, 2243,
    2383, 2607, 2829, 3276, 3728, 4186, 4648, 5116, 5589, 6068,
    6552, 7041, 7535, 8036, 8543, 9056, 9576, 10103, 10638, 11182,
    11734, 12297, 12697, 12870, 13456, 13575 };

  // 1e6 Pa units
  localparam longint CRUST_MPA [POINTS] = '{
    0, 82, 410, 670, 1120, 1780, 2450, 3610, 4780, 5940,
    7110, 8640, 10200, 11770, 13350, 15220, 17130, 19070, 21040, 22430,
    23830, 26070, 28290, 32760, 37280, 41860, 46480, 51160, 55890, 60680,
    65520, 70410, 75350, 80360, 85430, 90560, 95760, 101030, 106380, 111820,
    117340, 122970, 126970, 128700, 134560, 135750 };

  typedef struct {
    logic signed [ELEV_W-1:0] elevation;
    logic signed [PRES_W-1:0] pressure;
    logic                     saturated;
  } pressure_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PRESSURE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                     elev_valid   = 1'b0;
  logic signed [ELEV_W-1:0] elev_data    = '0;
  logic                     result_ready = 1'b0;

  // register copies, reset values
  logic [1:0]  cur_mode      = MODE_LITHO;
  logic        cur_diffusion = 1'b0;
  logic [15:0] cur_density   = 16'd3000;
  logic [15:0] cur_porosity  = 16'd0;
  logic [23:0] cur_gravity   = 24'd655360;

  logic signed [ELEV_W-1:0] elev_pending [$];
  pressure_beat_t           pressure_due [$];

  int          errors     = 0;
  int          burst_left = 8;
  int          gap_left   = 0;
  int unsigned stall_count = 0;
  logic [1:0]  stall_style = 2'd0;
  int unsigned cycles     = 0;

  rpp_in_if  sample_if ();
  rpp_out_if result_if ();

  assign sample_if.valid     = elev_valid;
  assign sample_if.elevation = elev_data;
  assign result_if.ready     = result_ready;

  reference_pressure_profile #(.TABLE_POINTS(POINTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_if),
    .result    (result_if)
  );

  always #2 clk = ~clk;

  function automatic longint point_pa(input logic crust, input int idx);
    return crust ? CRUST_MPA[idx] * 1000000 : STD_10MPA[idx] * 10000000;
  endfunction

  function automatic longint table_pressure(input logic crust, input longint depth_q8);
    int     n;
    longint d0, d1, p0, p1, num, den;
    if (depth_q8 <= 0) return 0;
    n = 1;
    while (n < POINTS && depth_q8 > BREAK_DEPTH_M[n] * 256) n++;
    if (n == POINTS) return point_pa(crust, POINTS - 1);
    d0  = BREAK_DEPTH_M[n-1] * 256;
    d1  = BREAK_DEPTH_M[n] * 256;
    p0  = point_pa(crust, n - 1);
    p1  = point_pa(crust, n);
    den = d1 - d0;
    num = (p1 - p0) * (depth_q8 - d0);
    // both tables rise with depth, so the step is never negative
    return p0 + (num + den / 2) / den;
  endfunction

  function automatic pressure_beat_t expected_pressure(input logic signed [ELEV_W-1:0] elev);
    pressure_beat_t beat;
    longint         depth;
    logic [63:0]    mag;
    logic [127:0]   rho, prod, res;
    beat.elevation = elev;
    beat.pressure  = '0;
    beat.saturated = 1'b0;
    depth = -longint'(elev);
    case (cur_mode)
      MODE_LITHO: begin
        mag = (depth < 0) ? 64'(-depth) : 64'(depth);
        if (cur_diffusion) begin
          rho = 128'(cur_density) * 128'(65536 - int'(cur_porosity))
              + 128'(1000) * 128'(cur_porosity);
        end else begin
          rho = 128'(cur_density) << 16;
        end
        prod = rho * 128'(cur_gravity) * 128'(mag) + (128'(1) << 39);
        res  = prod >> 40;
        if (depth < 0) begin
          if (res > (128'(1) << 40)) begin
            beat.pressure  = PRES_MIN;
            beat.saturated = 1'b1;
          end else begin
            beat.pressure = PRES_W'(-res);
          end
        end else if (res > (128'(1) << 40) - 1) begin
          beat.pressure  = PRES_MAX;
          beat.saturated = 1'b1;
        end else begin
          beat.pressure = PRES_W'(res);
        end
      end
      MODE_STD, MODE_CRUST: begin
        beat.pressure = PRES_W'(table_pressure(cur_mode == MODE_CRUST, depth));
      end
      default: begin
        beat.pressure = '0;
      end
    endcase
    return beat;
  endfunction

  function automatic logic signed [ELEV_W-1:0] pick_elevation(input logic [1:0] mode);
    int r;
    int k;
    r = $urandom_range(0, 9);
    if (mode == MODE_STD || mode == MODE_CRUST) begin
      if (r < 5) return -$signed(32'($urandom_range(0, 745000000)));
      if (r < 8) begin
        k = $urandom_range(1, POINTS - 1);
        return 32'(-(BREAK_DEPTH_M[k] * 256 + longint'($urandom_range(0, 4)) - 2));
      end
      return $signed($urandom);
    end
    if (r < 4) return $signed($urandom);
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [15:0] pick_u16();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_PRESSURE_MODE: cur_mode      = data[1:0];
      CFG_HYD_DIFFUSION: cur_diffusion = data[0];
      CFG_REF_DENSITY:   cur_density   = data[15:0];
      CFG_REF_POROSITY:  cur_porosity  = data[15:0];
      CFG_GRAVITY:       cur_gravity   = data[23:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] mode, input logic diffusion,
                           input logic [15:0] density, input logic [15:0] porosity,
                           input logic [23:0] grav);
    write_reg(CFG_PRESSURE_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_HYD_DIFFUSION, CFG_DATA_W'(diffusion));
    write_reg(CFG_REF_DENSITY, CFG_DATA_W'(density));
    write_reg(CFG_REF_POROSITY, CFG_DATA_W'(porosity));
    write_reg(CFG_GRAVITY, grav);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // sender holds off until every pending result is back
  task automatic drain();
    do @(negedge clk);
    while (elev_pending.size() != 0 || elev_valid || pressure_due.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      elev_valid <= 1'b0;
    end else begin
      if (elev_valid && sample_if.ready) pressure_due.push_back(expected_pressure(elev_data));
      if (!elev_valid || sample_if.ready) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          elev_valid <= 1'b0;
        end else if (elev_pending.size() == 0) begin
          elev_valid <= 1'b0;
        end else begin
          elev_valid <= 1'b1;
          elev_data  <= elev_pending.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count[6:0] == 7'd0) stall_style <= 2'($urandom_range(0, 3));
      case (stall_style)
        2'd0: result_ready <= 1'b1;
        2'd1: result_ready <= 1'($urandom_range(0, 1));
        2'd2: result_ready <= (stall_count[1:0] != 2'd0);
        default: result_ready <= stall_count[4];
      endcase
      if (result_if.valid && result_ready) begin
        if (pressure_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, pressure %0d", result_if.pressure));
        end else begin
          pressure_beat_t want;
          want = pressure_due.pop_front();
          if (result_if.pressure !== want.pressure)
            report_mismatch($sformatf("elevation %0d mode %0d: pressure %0d, want %0d",
                                      want.elevation, cur_mode, result_if.pressure,
                                      want.pressure));
          if (result_if.saturated !== want.saturated)
            report_mismatch($sformatf("elevation %0d mode %0d: saturated %0b, want %0b",
                                      want.elevation, cur_mode, result_if.saturated,
                                      want.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          n;
    logic [1:0]  mode;
    logic [23:0] grav;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: lithostatic, density 3000, g = 10
    elev_pending.push_back(32'sd0);
    elev_pending.push_back(-32'sd1);
    elev_pending.push_back(32'sd1);
    elev_pending.push_back(-32'sd128);
    elev_pending.push_back(-32'sd256000);
    elev_pending.push_back(32'sh7FFFFFFF);
    elev_pending.push_back(32'sh80000000);
    drain();

    // largest density and gravity: clamps on both sides
    configure(MODE_LITHO, 1'b0, 16'hFFFF, 16'd0, 24'hFFFFFF);
    elev_pending.push_back(32'sh80000000);
    elev_pending.push_back(32'sh7FFFFFFF);
    elev_pending.push_back(-32'sd1);
    elev_pending.push_back(32'sd1);
    drain();

    // water mixing at full porosity
    configure(MODE_LITHO, 1'b1, 16'hFFFF, 16'hFFFF, 24'd655360);
    elev_pending.push_back(-32'sd2560);
    elev_pending.push_back(32'sd2560);
    elev_pending.push_back(32'sh80000000);
    drain();

    // standard table: surface, breakpoints, past the last breakpoint
    configure(MODE_STD, 1'b1, 16'd3000, 16'd0, 24'd655360);
    elev_pending.push_back(32'sd0);
    elev_pending.push_back(32'sd1);
    elev_pending.push_back(-32'sd1);
    elev_pending.push_back(-32'sd768000);
    elev_pending.push_back(-32'sd768001);
    elev_pending.push_back(-32'sd740096000);
    elev_pending.push_back(-32'sd740096001);
    elev_pending.push_back(32'sh80000000);
    drain();

    configure(MODE_CRUST, 1'b0, 16'd0, 16'd0, 24'd0);
    elev_pending.push_back(-32'sd128);
    elev_pending.push_back(-32'sd6246400);
    elev_pending.push_back(-32'sd740095999);
    drain();

    configure(MODE_UNUSED, 1'b0, 16'd3000, 16'd0, 24'd655360);
    elev_pending.push_back(-32'sd256000);
    elev_pending.push_back(32'sd256000);
    drain();

    for (ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        mode = 2'(ph);
      end else begin
        n = $urandom_range(0, 19);
        mode = (n < 8) ? MODE_LITHO : (n < 13) ? MODE_STD : (n < 18) ? MODE_CRUST
                                                                      : MODE_UNUSED;
      end
      case ($urandom_range(0, 4))
        0: grav = 24'd0;
        1: grav = 24'hFFFFFF;
        2: grav = 24'($urandom_range(600000, 700000));
        default: grav = 24'($urandom);
      endcase
      configure(mode, 1'($urandom_range(0, 1)), pick_u16(), pick_u16(), grav);
      n = (mode == MODE_UNUSED) ? 10 : 50;
      repeat (n) elev_pending.push_back(pick_elevation(mode));
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (pressure_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pressure_due.size()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rpp_pkg.sv
src/rpp_in_if.sv
src/rpp_out_if.sv
src/rpp_div.sv
src/reference_pressure_profile.sv
test/tb_top.sv
